[rtl/core/ws2812_pixel_pwm_encoder_core_macros.svh]
// Assertion macros of the pixel PWM encoder, used by the back end.
`ifndef WS2812_PIXEL_PWM_ENCODER_CORE_MACROS_SVH
`define WS2812_PIXEL_PWM_ENCODER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WPPE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, checked outside reset.
`define WPPE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

[rtl/core/wppe_pkg.sv]
// Shared types and constants of the pixel PWM encoder.
package wppe_pkg;

    // Field widths.
    localparam int C_DUTY_W  = 8;
    localparam int C_COUNT_W = 11;
    localparam int C_WORD_W  = 24;
    localparam int C_CFG_AW  = 2;
    localparam int C_CFG_DW  = 11;

    // Bit slots per LED and the slot counter.
    localparam int                 C_SLOT_W    = 5;
    localparam logic [C_SLOT_W-1:0] C_LAST_SLOT = 5'd23;

    // Frame limit compare width and the hard LED limit.
    localparam int                C_LIM_W    = 17;
    localparam logic [C_LIM_W-1:0] C_MAX_LEDS = 17'd1024;

    // Reset value of the LED count register.
    localparam logic [C_COUNT_W-1:0] C_TOTAL_LEDS_RST = 11'd1024;

    // Default depth of the command queue between front and back.
    localparam int C_QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic [C_CFG_AW-1:0] C_REG_HIGH_DUTY  = 2'd0;
    localparam logic [C_CFG_AW-1:0] C_REG_LOW_DUTY   = 2'd1;
    localparam logic [C_CFG_AW-1:0] C_REG_TOTAL_LEDS = 2'd2;

    // Configuration seen by the front and back.
    typedef struct packed {
        logic [C_DUTY_W-1:0]  high_duty;
        logic [C_DUTY_W-1:0]  low_duty;
        logic [C_COUNT_W-1:0] total_leds;
    } t_cfg;

    // One classified LED command.
    typedef struct packed {
        logic                overflow;
        logic                blank;
        logic                frame_end;
        logic [C_WORD_W-1:0] word;
    } t_cmd;

    // Result flags; is_latch sits in the lowest bit.
    typedef struct packed {
        logic overflow;
        logic is_latch;
    } t_flags;

    // Back-end sequencer phases.
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SLOTS,
        PH_OVF,
        PH_LATCH
    } t_phase;

endpackage

[rtl/core/ws2812_pixel_pwm_encoder_core.sv]
// Top level of the pixel PWM encoder: configuration registers and stream ports.
//
// Each accepted LED item yields PWM compare values, one per output cycle while
// the output is not stalled: 24 slot results for a color or blank LED (G, R, B,
// MSB first), or a single overflow result for an LED beyond the frame limit,
// followed by one latch result when the item carries tlast. The back-end slot
// sequencer takes the next command as it issues the final result of the current
// one. The front end takes one item per cycle while the command queue of
// QUEUE_DEPTH entries has room, so input and output stall independently.
// Configuration must be written only while no item is in flight.
module ws2812_pixel_pwm_encoder_core
    import wppe_pkg::*;
#(
    parameter int QUEUE_DEPTH = C_QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration write port.
    input  logic                i_cfg_we,
    input  logic [C_CFG_AW-1:0] i_cfg_addr,
    input  logic [C_CFG_DW-1:0] i_cfg_wdata,
    // LED items in.
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [23:0]         s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
    input  logic                s_axis_tuser,   // mode: 1 for a blank LED
    input  logic                s_axis_tlast,   // frame_end
    // Slot results out.
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [7:0]          m_axis_tdata,   // duty [7:0]
    output logic [1:0]          m_axis_tuser,   // is_latch [0], overflow [1]
    output logic                m_axis_tlast    // last
);

    logic [C_DUTY_W-1:0]  r_high_duty;
    logic [C_DUTY_W-1:0]  r_low_duty;
    logic [C_COUNT_W-1:0] r_total_leds;
    t_cfg                 w_cfg;

    logic                 w_fq_valid;
    logic                 w_fq_ready;
    t_cmd                 w_fq_data;
    logic                 w_qb_valid;
    logic                 w_qb_ready;
    t_cmd                 w_qb_data;
    t_flags               w_flags;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_duty  <= '0;
            r_low_duty   <= '0;
            r_total_leds <= C_TOTAL_LEDS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                C_REG_HIGH_DUTY:  r_high_duty  <= i_cfg_wdata[C_DUTY_W-1:0];
                C_REG_LOW_DUTY:   r_low_duty   <= i_cfg_wdata[C_DUTY_W-1:0];
                C_REG_TOTAL_LEDS: r_total_leds <= i_cfg_wdata[C_COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_cfg.high_duty  = r_high_duty;
        w_cfg.low_duty   = r_low_duty;
        w_cfg.total_leds = r_total_leds;
    end

    // Front end.
    wppe_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_s_valid     (s_axis_tvalid),
        .o_s_ready     (s_axis_tready),
        .i_s_blank     (s_axis_tuser),
        .i_s_red       (s_axis_tdata[7:0]),
        .i_s_green     (s_axis_tdata[15:8]),
        .i_s_blue      (s_axis_tdata[23:16]),
        .i_s_frame_end (s_axis_tlast),
        .o_q_valid     (w_fq_valid),
        .i_q_ready     (w_fq_ready),
        .o_q_data      (w_fq_data)
    );

    // Command queue.
    wppe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (w_fq_valid),
        .o_in_ready  (w_fq_ready),
        .i_in_data   (w_fq_data),
        .o_out_valid (w_qb_valid),
        .i_out_ready (w_qb_ready),
        .o_out_data  (w_qb_data)
    );

    // Back end.
    wppe_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_q_valid (w_qb_valid),
        .o_q_ready (w_qb_ready),
        .i_q_data  (w_qb_data),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_m_duty  (m_axis_tdata),
        .o_m_flags (w_flags),
        .o_m_last  (m_axis_tlast)
    );

    assign m_axis_tuser = w_flags;

endmodule

[rtl/core/wppe_front.sv]
// Front end: accepts LED items, counts them per frame and classifies them.
module wppe_front
    import wppe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_s_valid,
    output logic                 o_s_ready,
    input  logic                 i_s_blank,
    input  logic [C_DUTY_W-1:0]  i_s_red,
    input  logic [C_DUTY_W-1:0]  i_s_green,
    input  logic [C_DUTY_W-1:0]  i_s_blue,
    input  logic                 i_s_frame_end,
    output logic                 o_q_valid,
    input  logic                 i_q_ready,
    output t_cmd                 o_q_data
);

    logic [C_COUNT_W-1:0] r_count;
    logic [C_COUNT_W-1:0] n_count;
    logic [C_LIM_W-1:0]   w_total_ext;
    logic [C_LIM_W-1:0]   w_limit;
    logic                 w_over;
    logic                 w_accept;

    // The limit in force is the smaller of the register and the hard limit.
    assign w_total_ext = {{(C_LIM_W-C_COUNT_W){1'b0}}, i_cfg.total_leds};
    assign w_limit     = (C_MAX_LEDS < w_total_ext) ? C_MAX_LEDS : w_total_ext;
    assign w_over      = {{(C_LIM_W-C_COUNT_W){1'b0}}, r_count} >= w_limit;

    // An item is taken whenever the queue has room.
    assign o_s_ready = i_q_ready;
    assign o_q_valid = i_s_valid;
    assign w_accept  = i_s_valid && i_q_ready;

    // Build the command: green, red, blue, each sent MSB first.
    always_comb begin
        o_q_data.overflow  = w_over;
        o_q_data.blank     = i_s_blank;
        o_q_data.frame_end = i_s_frame_end;
        o_q_data.word      = {i_s_green, i_s_red, i_s_blue};
    end

    // Frame count: clears on frame end, advances on a kept LED.
    always_comb begin
        n_count = r_count;
        if (w_accept) begin
            if (i_s_frame_end) begin
                n_count = '0;
            end else if (!w_over) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

[rtl/core/wppe_queue.sv]
// Short command queue between the front and the back end.
module wppe_queue
    import wppe_pkg::*;
#(
    parameter int DEPTH = C_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_cmd i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_in_ready  = r_count != CNT_W'(DEPTH);
    assign o_out_valid = r_count != '0;
    assign o_out_data  = r_mem[r_rd_ptr];
    assign w_push      = i_in_valid && o_in_ready;
    assign w_pop       = o_out_valid && i_out_ready;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_in_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/core/wppe_back.sv]
// Back end: turns queued commands into slot, overflow and latch results.
module wppe_back
    import wppe_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_q_valid,
    output logic                o_q_ready,
    input  t_cmd                i_q_data,
    output logic                o_m_valid,
    input  logic                i_m_ready,
    output logic [C_DUTY_W-1:0] o_m_duty,
    output t_flags              o_m_flags,
    output logic                o_m_last
);

`include "ws2812_pixel_pwm_encoder_core_macros.svh"

    t_phase              r_phase;
    t_phase              n_phase;
    logic [C_SLOT_W-1:0] r_slot;
    logic [C_WORD_W-1:0] r_word;
    logic                r_blank;
    logic                r_fend;

    logic                r_out_valid;
    logic [C_DUTY_W-1:0] r_out_duty;
    t_flags              r_out_flags;
    logic                r_out_last;

    logic                w_res_valid;
    logic [C_DUTY_W-1:0] w_res_duty;
    t_flags              w_res_flags;
    logic                w_res_last;
    logic                w_res_final;
    logic                w_adv;
    logic                w_step;
    logic                w_load;

    // Result of the current phase.
    always_comb begin
        w_res_valid = 1'b0;
        w_res_duty  = '0;
        w_res_flags = '0;
        w_res_last  = 1'b0;
        w_res_final = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
            end
            PH_SLOTS: begin
                w_res_valid = 1'b1;
                w_res_duty  = (!r_blank && r_word[C_WORD_W-1]) ? i_cfg.high_duty
                                                               : i_cfg.low_duty;
                w_res_last  = (r_slot == C_LAST_SLOT) && !r_fend;
                w_res_final = w_res_last;
            end
            PH_OVF: begin
                w_res_valid          = 1'b1;
                w_res_flags.overflow = 1'b1;
                w_res_last           = !r_fend;
                w_res_final          = !r_fend;
            end
            PH_LATCH: begin
                w_res_valid          = 1'b1;
                w_res_flags.is_latch = 1'b1;
                w_res_last           = 1'b1;
                w_res_final          = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // The output register moves when empty or taken.
    assign w_adv     = !r_out_valid || i_m_ready;
    assign w_step    = w_res_valid && w_adv;
    assign w_load    = i_q_valid && ((r_phase == PH_IDLE) || (w_step && w_res_final));
    assign o_q_ready = w_load;

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        priority if (w_load) begin
            n_phase = i_q_data.overflow ? PH_OVF : PH_SLOTS;
        end else if (w_step) begin
            unique case (r_phase)
                PH_SLOTS: begin
                    if (r_slot == C_LAST_SLOT) begin
                        n_phase = r_fend ? PH_LATCH : PH_IDLE;
                    end
                end
                PH_OVF:   n_phase = r_fend ? PH_LATCH : PH_IDLE;
                PH_LATCH: n_phase = PH_IDLE;
                default:  n_phase = PH_IDLE;
            endcase
        end
    end

    // Sequencer control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_slot  <= '0;
        end else begin
            r_phase <= n_phase;
            if (w_load) begin
                r_slot <= '0;
            end else if (w_step && (r_phase == PH_SLOTS)) begin
                r_slot <= r_slot + 1'b1;
            end
        end
    end

    // Command payload; the color word shifts one bit per slot.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_word  <= i_q_data.word;
            r_blank <= i_q_data.blank;
            r_fend  <= i_q_data.frame_end;
        end else if (w_step && (r_phase == PH_SLOTS)) begin
            r_word <= {r_word[C_WORD_W-2:0], 1'b0};
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_duty  <= w_res_duty;
            r_out_flags <= w_res_flags;
            r_out_last  <= w_res_last;
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_duty  = r_out_duty;
    assign o_m_flags = r_out_flags;
    assign o_m_last  = r_out_last;

    // A latch result always closes its item and carries no duty.
    `WPPE_ASSERT_IMP(a_latch_last, i_clk, i_rst_n, r_out_valid && r_out_flags.is_latch,
        r_out_last && (r_out_duty == '0) && !r_out_flags.overflow)
    // A new command is only taken when the sequencer finishes or idles.
    `WPPE_ASSERT_IMP(a_load_ok, i_clk, i_rst_n, w_load,
        (r_phase == PH_IDLE) || (w_step && w_res_final))
    // A frame-end pixel goes on to the latch after its last slot.
    `WPPE_ASSERT_NXT(a_slot_latch, i_clk, i_rst_n,
        w_step && (r_phase == PH_SLOTS) && (r_slot == C_LAST_SLOT) && r_fend,
        r_phase == PH_LATCH)

endmodule

[tb/ws2812_pixel_pwm_encoder_core_tb.sv]
// Self-checking testbench for the WS2812 pixel PWM encoder core.
module ws2812_pixel_pwm_encoder_core_tb;
    import wppe_pkg::*;

    // One LED item as offered on the input stream.
    typedef struct packed {
        logic       mode;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } led_item_t;

    // One bit-slot result as seen on the output stream.
    typedef struct packed {
        logic [7:0] duty;
        logic       is_latch;
        logic       overflow;
        logic       last;
    } slot_t;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [C_CFG_AW-1:0] i_cfg_addr = '0;
    logic [C_CFG_DW-1:0] i_cfg_wdata = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [23:0]         s_axis_tdata = '0;   // red [7:0], green [15:8], blue [23:16]
    logic                s_axis_tuser = 1'b0; // mode
    logic                s_axis_tlast = 1'b0; // frame_end
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [7:0]          m_axis_tdata;        // duty [7:0]
    logic [1:0]          m_axis_tuser;        // is_latch [0], overflow [1]
    logic                m_axis_tlast;        // last

    ws2812_pixel_pwm_encoder_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    // Predictor state: configuration copy and the LED count of the frame.
    logic [7:0]           cfg_high_duty  = 8'd0;
    logic [7:0]           cfg_low_duty   = 8'd0;
    logic [C_COUNT_W-1:0] cfg_total_leds = C_TOTAL_LEDS_RST;
    logic [C_COUNT_W-1:0] frame_leds     = '0;

    led_item_t pending_leds[$];
    slot_t     expected_slots[$];

    int  mismatches  = 0;
    int  cycle_count = 0;
    int  idle_pct    = 16;
    int  hold_asks   = 0;
    int  hold_seen   = 0;
    int  hold_left   = 0;
    logic led_taken  = 1'b0;

    // Clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Work out the slot results that one accepted LED item causes.
    function automatic void encode_led(input led_item_t led);
        logic [C_LIM_W-1:0] limit;
        logic [23:0]        word;
        slot_t              res;
        limit = (C_LIM_W'(cfg_total_leds) > C_MAX_LEDS) ? C_MAX_LEDS : C_LIM_W'(cfg_total_leds);
        if (C_LIM_W'(frame_leds) >= limit) begin
            // Dropped LED: one overflow result, count unchanged.
            res = '{duty: 8'd0, is_latch: 1'b0, overflow: 1'b1, last: !led.frame_end};
            expected_slots.push_back(res);
        end else begin
            // Green, red, blue, each byte most significant bit first.
            word = {led.green, led.red, led.blue};
            for (int s = 0; s < 24; s++) begin
                res.duty     = (!led.mode && word[23-s]) ? cfg_high_duty : cfg_low_duty;
                res.is_latch = 1'b0;
                res.overflow = 1'b0;
                res.last     = (s == 23) && !led.frame_end;
                expected_slots.push_back(res);
            end
            frame_leds = frame_leds + 1'b1;
        end
        if (led.frame_end) begin
            res = '{duty: 8'd0, is_latch: 1'b1, overflow: 1'b0, last: 1'b1};
            expected_slots.push_back(res);
            frame_leds = '0;
        end
    endfunction

    function automatic void check_field(input string fname, input int want, input int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
        end
    endfunction

    // Output check, input capture and the run limit.
    always @(posedge i_clk) begin : monitor_p
        slot_t     want;
        led_item_t led;
        t_flags    flags;
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            // Compare each result with the oldest expectation.
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                flags = t_flags'(m_axis_tuser);
                if (expected_slots.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none, actual duty %0d tuser %b",
                             $time, m_axis_tdata, m_axis_tuser);
                end else begin
                    want = expected_slots.pop_front();
                    check_field("duty", int'(want.duty), int'(m_axis_tdata));
                    check_field("is_latch", int'(want.is_latch), int'(flags.is_latch));
                    check_field("overflow", int'(want.overflow), int'(flags.overflow));
                    check_field("last", int'(want.last), int'(m_axis_tlast));
                end
            end
            // Predict the results of each accepted item.
            if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
                led.mode      = s_axis_tuser;
                led.red       = s_axis_tdata[7:0];
                led.green     = s_axis_tdata[15:8];
                led.blue      = s_axis_tdata[23:16];
                led.frame_end = s_axis_tlast;
                encode_led(led);
            end
            led_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        end
    end

    // Input driver: holds an item until taken, then offers the next or idles.
    always @(negedge i_clk) begin : driver_p
        led_item_t nxt;
        if (i_rst_n && !(s_axis_tvalid && !led_taken)) begin
            if (pending_leds.size() != 0 && $urandom_range(99) >= idle_pct) begin
                nxt = pending_leds.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {nxt.blue, nxt.green, nxt.red};
                s_axis_tuser  <= nxt.mode;
                s_axis_tlast  <= nxt.frame_end;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output receiver: random stalls plus a long hold-off on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_seen != hold_asks) begin
            hold_seen     <= hold_asks;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    task automatic add_led(input logic mode, input logic [7:0] red, input logic [7:0] green,
                           input logic [7:0] blue, input logic frame_end);
        led_item_t led;
        led = '{mode: mode, red: red, green: green, blue: blue, frame_end: frame_end};
        pending_leds.push_back(led);
    endtask

    // Random frames; a few lose their frame end to leave a frame open.
    task automatic queue_frames(input int n_items, input int max_len);
        int len;
        int k;
        k = 0;
        while (k < n_items) begin
            len = $urandom_range(max_len, 1);
            for (int j = 0; j < len && k < n_items; j++) begin
                add_led($urandom_range(7) == 0, 8'($urandom), 8'($urandom), 8'($urandom),
                        (j == len - 1) && ($urandom_range(9) != 0));
                k++;
            end
        end
    endtask

    // Wait until nothing is queued, offered or expected, then let the block settle.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_leds.size() != 0 || s_axis_tvalid || expected_slots.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [C_CFG_AW-1:0] idx, input logic [C_CFG_DW-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            C_REG_HIGH_DUTY:  cfg_high_duty  = val[7:0];
            C_REG_LOW_DUTY:   cfg_low_duty   = val[7:0];
            C_REG_TOTAL_LEDS: cfg_total_leds = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Drain the block, then load a full register setting.
    task automatic set_config(input logic [7:0] high, input logic [7:0] low,
                              input logic [C_COUNT_W-1:0] total);
        wait_idle();
        write_reg(C_REG_HIGH_DUTY, C_CFG_DW'(high));
        write_reg(C_REG_LOW_DUTY, C_CFG_DW'(low));
        write_reg(C_REG_TOTAL_LEDS, total);
        @(posedge i_clk);
    endtask

    // Stimulus sequence and final verdict.
    initial begin : stimulus
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values of the registers.
        add_led(1'b0, 8'hFF, 8'h0F, 8'hA5, 1'b0);
        add_led(1'b0, 8'h12, 8'h34, 8'h56, 1'b1);

        // Directed: single channels, all ones, all zeros, patterns and blanks.
        set_config(8'd255, 8'd0, 11'd1024);
        add_led(1'b0, 8'hFF, 8'h00, 8'h00, 1'b0);
        add_led(1'b0, 8'h00, 8'hFF, 8'h00, 1'b0);
        add_led(1'b0, 8'h00, 8'h00, 8'hFF, 1'b0);
        add_led(1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        add_led(1'b0, 8'h00, 8'h00, 8'h00, 1'b0);
        add_led(1'b0, 8'hA5, 8'h5A, 8'h3C, 1'b0);
        add_led(1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        add_led(1'b1, 8'h00, 8'h00, 8'h00, 1'b1);
        add_led(1'b0, 8'h80, 8'h01, 8'h80, 1'b1);

        // Directed: limit of one LED, overflow with and without a frame end.
        set_config(8'd0, 8'd255, 11'd1);
        add_led(1'b0, 8'hFF, 8'h00, 8'hFF, 1'b0);
        add_led(1'b0, 8'h55, 8'hAA, 8'h55, 1'b0);
        add_led(1'b1, 8'h55, 8'hAA, 8'h55, 1'b1);
        add_led(1'b0, 8'hC3, 8'h3C, 8'h81, 1'b1);
        add_led(1'b1, 8'h7E, 8'hE7, 8'h18, 1'b1);

        // Directed: limit of zero, every LED overflows.
        set_config(8'd170, 8'd85, 11'd0);
        add_led(1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        add_led(1'b1, 8'h00, 8'h00, 8'h00, 1'b1);
        add_led(1'b0, 8'h01, 8'h02, 8'h04, 1'b1);

        // Random frames with a long output hold-off while items keep coming.
        set_config(8'($urandom), 8'($urandom), 11'd1024);
        queue_frames(60, 8);
        hold_asks = hold_asks + 1;

        // Short frame limit, frames often run past it.
        set_config(8'd255, 8'd0, 11'd3);
        queue_frames(50, 6);

        // A stretch with no idling on either side.
        set_config(8'($urandom), 8'($urandom), 11'd1024);
        idle_pct = 0;
        queue_frames(50, 10);

        set_config(8'd0, 8'd255, 11'd1);
        idle_pct = 16;
        queue_frames(40, 3);

        set_config(8'($urandom), 8'($urandom), 11'd0);
        queue_frames(30, 4);

        set_config(8'($urandom), 8'($urandom), 11'($urandom_range(8, 2)));
        queue_frames(60, 10);

        // Register above the hard limit.
        set_config(8'($urandom), 8'($urandom), 11'd2047);
        queue_frames(40, 8);

        wait_idle();
        repeat (30) @(posedge i_clk);
        if (mismatches == 0 && expected_slots.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
